/* rtl/core/planar_to_chunky_palette_unit_defines.svh */
// ----------------------------------------------------------------------------
// planar_to_chunky_palette_unit_defines
// Assertion macros used by the checker file of the converter.
// ----------------------------------------------------------------------------
`ifndef PLANAR_TO_CHUNKY_PALETTE_UNIT_DEFINES_SVH
`define PLANAR_TO_CHUNKY_PALETTE_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, codes and helpers for the planar to chunky palette converter.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int PTC_MAX_PLANES    = 8;
    localparam int PTC_PALETTE_DEPTH = 256;

    localparam int IDX_W   = 8;
    localparam int COLOR_W = 24;
    localparam int CFG_W   = 4;

    localparam logic [2:0] LAST_BIT     = 3'd7;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [3:0] PLANES_RESET = 4'd4;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_GROUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ORD_RGB  = 2'd0,
        ORD_RGBA = 2'd1,
        ORD_BGR  = 2'd2,
        ORD_BGRA = 2'd3
    } t_order;

    typedef enum logic {
        CFG_PLANE_COUNT  = 1'b0,
        CFG_OUTPUT_ORDER = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_op         op;
        logic [7:0]  palette_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [63:0] plane_bytes;
    } t_in_item;

    typedef struct packed {
        logic [7:0] chan_first;
        logic [7:0] chan_second;
        logic [7:0] chan_third;
        logic [7:0] chan_alpha;
        logic       has_alpha;
        logic       last_pixel;
    } t_out_item;

    // palette write port
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] rgb;
    } t_pal_wr;

    // palette read port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_pal_rd;

    // Bit bit_sel of each plane byte in use lands in bit k of the index.
    function automatic logic [IDX_W-1:0] ptc_gather(
        input logic [63:0] bytes,
        input logic [2:0]  bit_sel,
        input logic [3:0]  planes
    );
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < IDX_W; k++) begin
            if (4'(k) < planes) begin
                idx[k] = bytes[{3'(k), bit_sel}];
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/core/ptc_palette_ram.sv */
// ----------------------------------------------------------------------------
// ptc_palette_ram
// Palette store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ptc_palette_ram #(
    parameter int DEPTH = ptc_pkg::PTC_PALETTE_DEPTH
) (
    input  logic                         i_clk,
    input  ptc_pkg::t_pal_wr             i_wr,
    input  ptc_pkg::t_pal_rd             i_rd,
    output logic [ptc_pkg::COLOR_W-1:0]  o_q
);
    import ptc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic               wr_in_range;

    // writes beyond the depth are dropped
    assign wr_in_range = {1'b0, i_wr.idx} < (IDX_W + 1)'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_in_range) begin
            r_mem[i_wr.idx[AW-1:0]] <= i_wr.rgb;
        end
    end

    // read returns the old entry on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            o_q <= r_mem[i_rd.idx[AW-1:0]];
        end
    end

endmodule

/* rtl/core/planar_to_chunky_palette_unit.sv */
// ----------------------------------------------------------------------------
// planar_to_chunky_palette_unit
// Bitplane byte groups to chunky pixels through a 24-bit palette.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): a write item stores one palette entry;
// a group item carries one byte per plane and yields eight pixels, bit 7
// first, the last one flagged by last_pixel.
// Output channel (o_valid / i_stall): one pixel per cycle from an output
// register that holds while the receiver stalls.
// Config channel (i_cfg_valid / o_cfg_ready): plane count and channel order,
// always ready; write only while the unit is idle.
// A group item is registered into the lookup stage, and each pixel then
// passes the registered palette read. The single palette read port does one
// lookup per pixel; a following item is taken in the cycle of the group's
// last lookup, so groups stream with no gap. A receiver stall freezes
// lookup and output together and stalls the input during a group.
// Reset clears control and config (4 planes, rgb); palette contents stay
// undefined until written.
// ----------------------------------------------------------------------------
module planar_to_chunky_palette_unit #(
    parameter int MAX_PLANES    = ptc_pkg::PTC_MAX_PLANES,
    parameter int PALETTE_DEPTH = ptc_pkg::PTC_PALETTE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  ptc_pkg::t_in_item          i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output ptc_pkg::t_out_item         o_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  ptc_pkg::t_cfg_reg          i_cfg_index,
    input  logic [ptc_pkg::CFG_W-1:0]  i_cfg_data
);
    import ptc_pkg::*;

    // config
    logic [3:0] r_plane_count;
    t_order     r_order;

    // lookup stage
    logic        r_busy,  n_busy;
    logic [2:0]  r_bit,   n_bit;
    logic [63:0] r_bytes, n_bytes;

    // output stage
    logic r_out_valid, n_out_valid;
    logic r_out_last,  n_out_last;
    logic r_out_oob,   n_out_oob;

    logic               advance;
    logic               in_free;
    logic               accept;
    logic [3:0]         planes;
    logic [IDX_W-1:0]   lut_idx;
    logic [COLOR_W-1:0] ram_q;
    logic [COLOR_W-1:0] color;
    logic               bgr;
    t_pal_wr            pal_wr;
    t_pal_rd            pal_rd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_count <= PLANES_RESET;
            r_order       <= ORD_RGB;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PLANE_COUNT:  r_plane_count <= i_cfg_data;
                CFG_OUTPUT_ORDER: r_order       <= t_order'(i_cfg_data[1:0]);
                default:          r_order       <= r_order;
            endcase
        end
    end

    assign planes = (r_plane_count > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : r_plane_count;

    assign advance = !r_out_valid || !i_stall;
    // free once the last lookup of the current group issues
    assign in_free = !r_busy || (advance && (r_bit == '0));
    assign o_stall = !in_free;
    assign accept  = i_valid && in_free;

    assign lut_idx = ptc_gather(r_bytes, r_bit, planes);

    always_comb begin
        pal_wr.en  = accept && (i_data.op == OP_WRITE);
        pal_wr.idx = i_data.palette_index;
        pal_wr.rgb = {i_data.red_in, i_data.green_in, i_data.blue_in};
        pal_rd.en  = advance && r_busy;
        pal_rd.idx = lut_idx;
    end

    ptc_palette_ram #(
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .i_clk (i_clk),
        .i_wr  (pal_wr),
        .i_rd  (pal_rd),
        .o_q   (ram_q)
    );

    always_comb begin
        n_busy      = r_busy;
        n_bit       = r_bit;
        n_bytes     = r_bytes;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_oob   = r_out_oob;
        if (advance) begin
            n_out_valid = r_busy;
            n_out_last  = (r_bit == '0);
            n_out_oob   = {1'b0, lut_idx} >= (IDX_W + 1)'(PALETTE_DEPTH);
            if (r_busy) begin
                n_bit = r_bit - 3'd1;
                if (r_bit == '0) begin
                    n_busy = 1'b0;
                end
            end
        end
        if (accept && (i_data.op == OP_GROUP)) begin
            n_busy  = 1'b1;
            n_bit   = LAST_BIT;
            n_bytes = i_data.plane_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit      <= n_bit;
        r_bytes    <= n_bytes;
        r_out_last <= n_out_last;
        r_out_oob  <= n_out_oob;
    end

    // out-of-range lookups read as black
    assign color = r_out_oob ? '0 : ram_q;
    assign bgr   = (r_order == ORD_BGR) || (r_order == ORD_BGRA);

    always_comb begin
        o_data.chan_first  = bgr ? color[7:0] : color[23:16];
        o_data.chan_second = color[15:8];
        o_data.chan_third  = bgr ? color[23:16] : color[7:0];
        o_data.last_pixel  = r_out_last;
        case (r_order)
            ORD_RGBA: begin
                o_data.chan_alpha = ALPHA_OPAQUE;
                o_data.has_alpha  = 1'b1;
            end
            ORD_BGRA: begin
                o_data.chan_alpha = '0;
                o_data.has_alpha  = 1'b1;
            end
            default: begin
                o_data.chan_alpha = '0;
                o_data.has_alpha  = 1'b0;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

/* rtl/core/ptc_checker.sv */
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the planar to chunky palette converter.
// ----------------------------------------------------------------------------
`include "planar_to_chunky_palette_unit_defines.svh"

module ptc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input ptc_pkg::t_in_item         i_data,
    input logic                      o_valid,
    input logic                      i_stall,
    input ptc_pkg::t_out_item        o_data
);
    import ptc_pkg::*;

    logic in_acc_group;
    logic in_acc_write;

    assign in_acc_group = i_valid && !o_stall && (i_data.op == OP_GROUP);
    assign in_acc_write = i_valid && !o_stall && (i_data.op == OP_WRITE);

    `PTC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data), "stalled pixel changed")

    // a group keeps the input busy for its remaining pixels
    `PTC_ASSERT_NEXT(a_group_busy, in_acc_group, o_stall, "input free right after a group item")

    // a palette write never leaves work behind it
    `PTC_ASSERT_NEXT(a_write_free, in_acc_write, !o_stall, "input busy right after a write item")

    `PTC_ASSERT_NOW(a_alpha_zero, o_valid && !o_data.has_alpha, o_data.chan_alpha == '0, "alpha set without alpha channel")

endmodule

bind planar_to_chunky_palette_unit ptc_checker u_ptc_checker (.*);
